/* hw/rtl/keyframe_vec3_lerp_unit_defines.svh */
// Assertion macros for the keyframe lerp unit.
// No dependencies.
`ifndef KEYFRAME_VEC3_LERP_UNIT_DEFINES_SVH
`define KEYFRAME_VEC3_LERP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KVL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KVL_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVL_ASSERT(label, clk, rstn, prop, msg)
`define KVL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/kvl_pkg.sv */
// Package for the keyframe lerp unit: types, constants.
// No dependencies.
`default_nettype none
package kvl_pkg;
    localparam int unsigned MAX_KEYS_DEF  = 64;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_Z = 2'd3;
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam int unsigned IN_W  = 168;
    localparam int unsigned OUT_W = 96;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CMP, ST_DIV, ST_MUL, ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* hw/rtl/keyframe_vec3_lerp_unit.sv */
// Keyframe vec3 lerp unit: time-sorted key table with linear interpolation.
// Depends on kvl_pkg and keyframe_vec3_lerp_unit_defines.svh.
//
// One item at a time. A query reads key i through ST_READ and ST_CMP from
// the key memory (one synchronous read port, registered data) until the
// first key at or above the query time, then runs a restoring divider for
// u, three multiplies and hands the item to the output register. A hit at
// key 0 skips the divider and the multiplies; when no key matches, the
// default registers are output. The next item is accepted in the cycle
// after the result leaves.
`default_nettype none
`include "keyframe_vec3_lerp_unit_defines.svh"
module keyframe_vec3_lerp_unit #(
    parameter int unsigned MAX_KEYS  = kvl_pkg::MAX_KEYS_DEF,
    parameter int unsigned FRAC_BITS = kvl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [kvl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kvl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // key_index, key_time, key_x, key_y, key_z, query_time (low to high)
    input  wire logic [kvl_pkg::IN_W-1:0]     s_tdata,
    // func
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // out_x, out_y, out_z (low to high)
    output logic [kvl_pkg::OUT_W-1:0]         m_tdata,
    // key_hit
    output logic                              m_tuser
);
    import kvl_pkg::*;

    localparam int unsigned AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned UW  = FRAC_BITS + 1;
    localparam int unsigned NW  = 32 + FRAC_BITS;
    localparam int unsigned DCW = $clog2(NW + 1);
    localparam int unsigned PW  = 33 + UW;

    // key memory: time, x, y, z
    logic [127:0] key_mem [MAX_KEYS];
    logic [127:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    logic [6:0]  key_count_reg;
    logic [31:0] def_x_reg, def_y_reg, def_z_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   qt_reg, qt_next;
    logic [127:0]  prev_reg, prev_next, cur_reg, cur_next;
    logic [NW-1:0] num_reg, num_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   den_reg, den_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [1:0]    mcnt_reg, mcnt_next;
    logic [31:0]   res_reg [3];
    logic [31:0]   res_next [3];
    logic          hit_reg, hit_next;
    logic          mvalid_reg, mvalid_next;

    logic [CW-1:0] n_eff;
    logic [32:0]   rem_sh;
    logic signed [32:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [33:0] sum;
    logic [5:0]    in_idx;

    assign in_idx = s_tdata[5:0];
    assign n_eff  = ({25'd0, key_count_reg} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                                                             : CW'(key_count_reg);
    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign wr_en  = s_tvalid && s_tready && (s_tuser == FUNC_LOAD)
                    && ({26'd0, in_idx} < 32'(MAX_KEYS));
    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[AW'(in_idx)] <= s_tdata[133:6];
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
            def_x_reg <= '0;
            def_y_reg <= '0;
            def_z_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_COUNT: key_count_reg <= cfg_data[6:0];
                REG_DEFAULT_X: def_x_reg <= cfg_data;
                REG_DEFAULT_Y: def_y_reg <= cfg_data;
                REG_DEFAULT_Z: def_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        idx_reg  <= idx_next;
        qt_reg   <= qt_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        dcnt_reg <= dcnt_next;
        mcnt_reg <= mcnt_next;
        res_reg  <= res_next;
        hit_reg  <= hit_next;
    end

    assign rem_sh = {rem_reg[31:0], num_reg[NW-1]};
    always_comb begin
        logic [31:0] a, b;
        a = prev_reg[32*mcnt_reg + 32 +: 32];
        b = cur_reg[32*mcnt_reg + 32 +: 32];
        diff = 33'(signed'(b)) - 33'(signed'(a));
        prod = PW'(diff) * signed'(PW'(num_reg[UW-1:0]));
        sum  = 34'(signed'(a)) + 34'(prod >>> FRAC_BITS);
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        qt_next = qt_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        dcnt_next = dcnt_reg;
        mcnt_next = mcnt_reg;
        res_next = res_reg;
        hit_next = hit_reg;
        mvalid_next = mvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready && s_tuser == FUNC_QUERY) begin
                    qt_next = s_tdata[165:134];
                    idx_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (idx_reg >= n_eff) begin
                    res_next[0] = def_x_reg;
                    res_next[1] = def_y_reg;
                    res_next[2] = def_z_reg;
                    hit_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cur_next = rd_data_reg;
                if (rd_data_reg[31:0] >= qt_reg) begin
                    hit_next = 1'b1;
                    if (idx_reg == '0) begin
                        res_next[0] = rd_data_reg[63:32];
                        res_next[1] = rd_data_reg[95:64];
                        res_next[2] = rd_data_reg[127:96];
                        state_next = ST_OUT;
                    end else begin
                        num_next = {qt_reg - prev_reg[31:0], FRAC_BITS'(0)};
                        den_next = rd_data_reg[31:0] - prev_reg[31:0];
                        rem_next = '0;
                        dcnt_next = DCW'(NW);
                        state_next = ST_DIV;
                    end
                end else begin
                    prev_next = rd_data_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DIV: begin
                if (dcnt_reg == '0) begin
                    mcnt_next = '0;
                    state_next = ST_MUL;
                end else begin
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_next = rem_sh - {1'b0, den_reg};
                        num_next = {num_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_next = rem_sh;
                        num_next = {num_reg[NW-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            ST_MUL: begin
                res_next[mcnt_reg] = sum[31:0];
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd2) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                mvalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {res_reg[2], res_reg[1], res_reg[0]};
    assign m_tuser  = hit_reg;

    `KVL_ASSERT(a_busy_no_ready, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_tready, "ready while busy")
    `KVL_ASSERT(a_out_from_state, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg) == ST_OUT, "output without finish")
    `KVL_ASSERT(a_no_write_busy, aclk, aresetn, wr_en |-> (state_reg == ST_IDLE), "load while busy")
    `KVL_ASSERT(a_u_range, aclk, aresetn, (state_reg == ST_MUL) |-> (num_reg <= NW'(1 << FRAC_BITS)), "u above one")
endmodule
`default_nettype wire
